### src/glcd_pkg.sv
// ----------------------------------------------------------------------------
// glcd_pkg: shared types and constants for the dual column display controller
// Command codes, decoded operation kinds and the word passed from the
// front end to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package glcd_pkg;

    // geometry defaults
    localparam int COLUMNS_PER_CHIP_DEF = 64;
    localparam int PAGE_COUNT_DEF       = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // command codes and their match masks
    localparam logic [7:0] CMD_DISPLAY    = 8'h3E;
    localparam logic [7:0] MASK_DISPLAY   = 8'hFE;
    localparam logic [7:0] CMD_COLUMN     = 8'h40;
    localparam logic [7:0] MASK_COLUMN    = 8'hC0;
    localparam logic [7:0] CMD_PAGE       = 8'hB8;
    localparam logic [7:0] MASK_PAGE      = 8'hF8;
    localparam logic [7:0] CMD_START_LINE = 8'hC0;
    localparam logic [7:0] MASK_START     = 8'hC0;

    // status byte: off flag in bit 5, busy and reset always clear
    localparam logic [7:0] STATUS_OFF = 8'h20;
    localparam logic [7:0] STATUS_ON  = 8'h00;

    localparam int CHIP_LEFT  = 0;
    localparam int CHIP_RIGHT = 1;
    localparam int CHIP_COUNT = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STATUS_RD,
        OP_DATA_RD,
        OP_DATA_WR,
        OP_DISPLAY,
        OP_COLUMN,
        OP_PAGE,
        OP_START_LINE
    } op_kind_t;

    // one classified bus access
    typedef struct packed {
        logic [CHIP_COUNT-1:0] sel;   // bit 0 left chip, bit 1 right chip
        op_kind_t              kind;
        logic [7:0]            arg;   // bus byte
    } glcd_op_t;

endpackage

`default_nettype wire

### src/glcd_front.sv
// ----------------------------------------------------------------------------
// glcd_front: access decoder and operation queue
// Classifies each accepted bus access into one operation and keeps it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_front
    import glcd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // access in
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     select_left,
    input  wire logic     select_right,
    input  wire logic     is_data,
    input  wire logic     is_read,
    input  wire logic [7:0] bus_byte,
    // operation out
    output logic          q_valid,
    input  wire logic     q_ready,
    output glcd_op_t      q_op
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    glcd_op_t             dec_op;
    glcd_op_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push, pop;

    // classify the access
    always_comb begin
        dec_op.sel  = {select_right, select_left};
        dec_op.arg  = bus_byte;
        dec_op.kind = OP_NONE;
        if (dec_op.sel != '0) begin
            if (is_read) begin
                dec_op.kind = is_data ? OP_DATA_RD : OP_STATUS_RD;
            end else if (is_data) begin
                dec_op.kind = OP_DATA_WR;
            end else if ((bus_byte & MASK_DISPLAY) == CMD_DISPLAY) begin
                dec_op.kind = OP_DISPLAY;
            end else if ((bus_byte & MASK_COLUMN) == CMD_COLUMN) begin
                dec_op.kind = OP_COLUMN;
            end else if ((bus_byte & MASK_PAGE) == CMD_PAGE) begin
                dec_op.kind = OP_PAGE;
            end else if ((bus_byte & MASK_START) == CMD_START_LINE) begin
                dec_op.kind = OP_START_LINE;
            end
        end
    end

    // queue control
    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_op     = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

`default_nettype wire

### src/glcd_back.sv
// ----------------------------------------------------------------------------
// glcd_back: per-chip registers, display memories and result register
// Executes one operation per cycle on the selected chips while no result
// word is left waiting, and registers the answer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_back
    import glcd_pkg::*;
#(
    parameter int COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
    parameter int PAGE_COUNT       = PAGE_COUNT_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // operation in
    input  wire logic     q_valid,
    output logic          q_ready,
    input  wire glcd_op_t q_op,
    // result out
    output logic          res_valid,
    input  wire logic     res_ready,
    output logic [7:0]    read_byte,
    output logic          read_valid
);

    localparam int CW    = $clog2(COLUMNS_PER_CHIP);
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int DEPTH = PAGE_COUNT * COLUMNS_PER_CHIP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  fire;
    logic                  who;          // answering chip: left unless only right
    logic [CHIP_COUNT-1:0] enabled;
    logic [7:0]            rdata [CHIP_COUNT];

    logic                  res_valid_reg, res_valid_next;
    op_kind_t              res_kind_reg;
    logic [7:0]            res_status_reg;
    logic                  res_who_reg;

    assign q_ready = !res_valid_reg || res_ready;
    assign fire    = q_valid && q_ready;
    assign who     = !q_op.sel[CHIP_LEFT];

    // per-chip state and display memory
    for (genvar g = 0; g < CHIP_COUNT; g++) begin : g_chip
        logic [PW-1:0] page_reg, page_next;
        logic [CW-1:0] column_reg, column_next;
        logic [5:0]    start_line_reg, start_line_next;
        logic          enabled_reg, enabled_next;
        logic [AW-1:0] addr;
        logic [CW-1:0] column_inc;
        logic [7:0]    mem [DEPTH];
        logic [7:0]    rdata_reg;

        assign addr = AW'(int'(page_reg) * COLUMNS_PER_CHIP + int'(column_reg));
        assign column_inc = (column_reg == CW'(COLUMNS_PER_CHIP - 1)) ? '0
                                                                    : column_reg + 1'b1;

        // register updates for a selected chip
        always_comb begin
            page_next       = page_reg;
            column_next     = column_reg;
            start_line_next = start_line_reg;
            enabled_next    = enabled_reg;
            if (fire && q_op.sel[g]) begin
                unique case (q_op.kind)
                    OP_DATA_RD, OP_DATA_WR: column_next = column_inc;
                    OP_DISPLAY:             enabled_next = q_op.arg[0];
                    OP_COLUMN: begin
                        if (int'(q_op.arg[5:0]) >= COLUMNS_PER_CHIP) begin
                            column_next = CW'(COLUMNS_PER_CHIP - 1);
                        end else begin
                            column_next = CW'(q_op.arg[5:0]);
                        end
                    end
                    OP_PAGE: begin
                        if (int'(q_op.arg[2:0]) >= PAGE_COUNT) begin
                            page_next = PW'(PAGE_COUNT - 1);
                        end else begin
                            page_next = PW'(q_op.arg[2:0]);
                        end
                    end
                    OP_START_LINE:          start_line_next = q_op.arg[5:0];
                    default: ;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                page_reg       <= '0;
                column_reg     <= '0;
                start_line_reg <= '0;
                enabled_reg    <= 1'b0;
            end else begin
                page_reg       <= page_next;
                column_reg     <= column_next;
                start_line_reg <= start_line_next;
                enabled_reg    <= enabled_next;
            end
        end

        // one write or one registered read per cycle
        always_ff @(posedge aclk) begin
            if (fire && q_op.sel[g] && (q_op.kind == OP_DATA_WR)) begin
                mem[addr] <= q_op.arg;
            end
            if (fire && (q_op.kind == OP_DATA_RD)) begin
                rdata_reg <= mem[addr];
            end
        end

        assign enabled[g] = enabled_reg;
        assign rdata[g]   = rdata_reg;
    end

    // result register, held while the result word waits
    always_comb begin
        res_valid_next = res_valid_reg;
        if (fire) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_kind_reg   <= q_op.kind;
            res_who_reg    <= who;
            res_status_reg <= enabled[who] ? STATUS_ON : STATUS_OFF;
        end
    end

    // result word
    always_comb begin
        case (res_kind_reg)
            OP_DATA_RD:   read_byte = rdata[res_who_reg];
            OP_STATUS_RD: read_byte = res_status_reg;
            default:      read_byte = 8'h00;
        endcase
        read_valid = (res_kind_reg inside {OP_DATA_RD, OP_STATUS_RD});
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

### src/dual_glcd_column_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_glcd_column_controller_unit: two-chip column display controller pair
// Stream wrapper around the access decoder/queue and the execution back end.
// ----------------------------------------------------------------------------
// Path: an accepted access word waits in the queue, then passes the execute
//   stage into the result register, which holds its result word.
// Throughput: one access word per cycle while result words are taken, set by
//   the execute stage and the one port of each chip's display memory.
// Reset: page, column, start line cleared and display off on both chips;
//   queue and result register empty. Display memory is left as it is.
`default_nettype none

module dual_glcd_column_controller_unit
    import glcd_pkg::*;
#(
    parameter int COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
    parameter int PAGE_COUNT       = PAGE_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // access words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [0] select_left, [1] select_right,
                                       // [9:2] bus_byte, [15:10] zero
    input  wire logic [1:0]  s_tuser,  // [0] is_data, [1] is_read
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // [7:0] read_byte
    output logic [0:0]       m_tuser   // [0] read_valid
);

    logic     q_valid;
    logic     q_ready;
    glcd_op_t q_op;
    logic     read_valid;

    glcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .select_left  (s_tdata[0]),
        .select_right (s_tdata[1]),
        .is_data      (s_tuser[0]),
        .is_read      (s_tuser[1]),
        .bus_byte     (s_tdata[9:2]),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_op         (q_op)
    );

    glcd_back #(
        .COLUMNS_PER_CHIP (COLUMNS_PER_CHIP),
        .PAGE_COUNT       (PAGE_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_op       (q_op),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .read_byte  (m_tdata),
        .read_valid (read_valid)
    );

    assign m_tuser[0] = read_valid;

    // an accepted word is waiting in the queue next cycle
    a_push_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> q_valid)
        else $error("accepted word missing from queue");

    // every executed operation yields a result word
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> m_tvalid)
        else $error("executed operation produced no result word");

    // reset empties queue and result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !q_valid)
        else $error("pipeline not empty after reset");

    // a result word that is still waiting blocks execution
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !q_ready)
        else $error("execute stage ran over a waiting result word");

endmodule

`default_nettype wire
